// ===== rtl/core/mpad_pkg.sv =====
// ----------------------------------------------------------------------------
// mpad_pkg
// Shared types and constants of the message period anomaly detector.
// ----------------------------------------------------------------------------
package mpad_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W   = 1;
  localparam int CAN_ID_W = 29;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int TOL_W    = 16;
  localparam int DEV_W    = 33;
  localparam int VERD_W   = 2;

  // period_ms * 1000 fits in 26 bits (65535000 < 2^26)
  localparam int PROD_W   = 26;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd6000;

  // Parameter defaults
  localparam int ID_BITS_DEFAULT     = 12;
  localparam int TIME_BITS_DEFAULT   = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Item kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_BAD_TIMING = 2'd1,
    VERDICT_UNKNOWN    = 2'd2,
    VERDICT_IGNORED    = 2'd3
  } verdict_t;

  // One classified word waiting between front and back
  typedef struct packed {
    logic                kind;
    logic                ignored;
    logic [CAN_ID_W-1:0] can_id;
    logic [TIME_W-1:0]   time_us;
    logic [PERIOD_W-1:0] period_ms;
  } item_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_CALC,
    B_FIN
  } back_state_t;

endpackage

// ===== rtl/core/mpad_front.sv =====
// ----------------------------------------------------------------------------
// mpad_front
// Accepts input words, flags out-of-range identifiers and pushes to the queue.
// ----------------------------------------------------------------------------
module mpad_front import mpad_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEFAULT
) (
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                kind,
  input  logic [CAN_ID_W-1:0] can_id,
  input  logic [TIME_W-1:0]   time_us,
  input  logic [PERIOD_W-1:0] period_ms,
  input  logic                clearing,
  input  logic                q_full,
  output logic                q_push,
  output item_t               q_word
);

  logic ignored;

  // Identifiers at or above 2^ID_BITS - 1 are out of range
  assign ignored = (|can_id[CAN_ID_W-1:ID_BITS]) || (&can_id[ID_BITS-1:0]);

  // Hold off while the tables are swept or the queue is full
  assign item_stall = clearing || q_full;
  assign q_push     = item_valid && !item_stall;

  always_comb begin
    q_word.kind      = kind;
    q_word.ignored   = ignored;
    q_word.can_id    = can_id;
    q_word.time_us   = time_us;
    q_word.period_ms = period_ms;
  end

endmodule

// ===== rtl/core/mpad_queue.sv =====
// ----------------------------------------------------------------------------
// mpad_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module mpad_queue import mpad_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_word,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/mpad_back.sv =====
// ----------------------------------------------------------------------------
// mpad_back
// Table lookup, period check, table write-back and result register.
// ----------------------------------------------------------------------------
module mpad_back import mpad_pkg::*; #(
  parameter int ID_BITS   = ID_BITS_DEFAULT,
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [TOL_W-1:0]       tolerance,
  input  item_t                  head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VERD_W-1:0]      verdict,
  output logic [CAN_ID_W-1:0]    flagged_id,
  output logic signed [DEV_W-1:0] deviation_us
);

  localparam int DEPTH = 1 << ID_BITS;
  localparam int TW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int ROW_W = PERIOD_W + 1;

  back_state_t state, state_next;

  // Row memory holds {seen, period}; cleared by sweep after reset
  logic [ROW_W-1:0] row_mem  [DEPTH];
  logic [TW-1:0]    time_mem [DEPTH];

  logic [ID_BITS-1:0] clr_addr;
  logic [ID_BITS-1:0] rd_addr;
  logic [ID_BITS-1:0] slot;
  logic [ROW_W-1:0]   row_q;
  logic [TW-1:0]      time_q;
  item_t              item;

  logic               out_free;
  logic               calc_en;
  logic               fin_en;

  logic [TW-1:0]      diff;
  logic [TIME_W-1:0]  elapsed;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    hi;
  logic [TIME_W:0]    ept;

  logic               row_we;
  logic [ID_BITS-1:0] row_waddr;
  logic [ROW_W-1:0]   row_wdata;
  logic               time_we;

  logic               seen_old;
  logic [PERIOD_W-1:0] per_old;
  logic               too_late;
  logic               too_early;
  logic signed [DEV_W-1:0] dev;
  verdict_t           verd_next;
  logic signed [DEV_W-1:0] dev_next;

  assign out_free = !result_valid || !result_stall;
  assign rd_addr  = head.can_id[ID_BITS-1:0];
  assign slot     = item.can_id[ID_BITS-1:0];
  assign seen_old = row_q[PERIOD_W];
  assign per_old  = row_q[PERIOD_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == '1) state_next = B_IDLE;
      B_IDLE:  if (!q_empty) state_next = B_CALC;
      B_CALC:  state_next = B_FIN;
      B_FIN:   if (out_free) state_next = B_IDLE;
      default: state_next = B_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    calc_en  = 1'b0;
    fin_en   = 1'b0;
    clearing = 1'b0;
    unique case (state)
      B_CLEAR: clearing = 1'b1;
      B_IDLE:  q_pop    = !q_empty;
      B_CALC:  calc_en  = 1'b1;
      B_FIN:   fin_en   = out_free;
      default: clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Read both tables as the word leaves the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      row_q  <= row_mem[rd_addr];
      time_q <= time_mem[rd_addr];
      item   <= head;
    end
  end

  // Elapsed time, expected period and tolerance bounds
  assign diff = item.time_us[TW-1:0] - time_q;

  always_ff @(posedge clk) begin
    if (calc_en) begin
      elapsed <= TIME_W'(diff);
      prod    <= PROD_W'(per_old * US_PER_MS);
      hi      <= (PROD_W + 1)'(PROD_W'(per_old * US_PER_MS)) + (PROD_W + 1)'(tolerance);
      ept     <= (TIME_W + 1)'(TIME_W'(diff)) + (TIME_W + 1)'(tolerance);
    end
  end

  // Verdict
  assign too_late  = ({1'b0, elapsed} > (TIME_W + 1)'(hi));
  assign too_early = (ept < (TIME_W + 1)'(prod));
  assign dev       = $signed({1'b0, elapsed}) - $signed(DEV_W'(prod));

  always_comb begin
    verd_next = VERDICT_OK;
    dev_next  = '0;
    if (item.ignored) begin
      verd_next = VERDICT_IGNORED;
    end else if (item.kind == KIND_LOAD) begin
      verd_next = VERDICT_OK;
    end else if (per_old == '0) begin
      verd_next = VERDICT_UNKNOWN;
    end else if (seen_old) begin
      dev_next  = dev;
      verd_next = (too_late || too_early) ? VERDICT_BAD_TIMING : VERDICT_OK;
    end
  end

  // Table write-back: sweep, load, or frame update
  always_comb begin
    row_we    = 1'b0;
    row_waddr = slot;
    row_wdata = row_q;
    time_we   = 1'b0;
    if (clearing) begin
      row_we    = 1'b1;
      row_waddr = clr_addr;
      row_wdata = '0;
    end else if (fin_en && !item.ignored) begin
      row_we = 1'b1;
      if (item.kind == KIND_LOAD) begin
        row_wdata = {seen_old, item.period_ms};
      end else begin
        row_wdata = {1'b1, per_old};
        time_we   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[slot] <= item.time_us[TW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_en) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      verdict      <= verd_next;
      flagged_id   <= item.can_id;
      deviation_us <= dev_next;
    end
  end

endmodule

// ===== rtl/core/message_period_anomaly_detector.sv =====
// ----------------------------------------------------------------------------
// message_period_anomaly_detector
// Checks bus frame arrival times against a per-identifier reference period.
// ----------------------------------------------------------------------------
// Timing: the back end takes no new word until the last has passed its idle,
//   compute and finish states, a read, compute, write-back loop over the
//   single-port tables; it waits in finish while the result is stalled.
// Reset: synchronous; after rst the period/seen table is swept, one entry a
//   cycle, over 2^ID_BITS entries (4096 at default) with item_stall held high.
// Configuration writes are taken at any time, including during the sweep.
// ----------------------------------------------------------------------------
module message_period_anomaly_detector import mpad_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEFAULT,
  parameter int TIME_BITS   = TIME_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration: tolerance in microseconds
  input  logic                    cfg_wr_en,
  input  logic [TOL_W-1:0]        cfg_wr_data,
  // Input words
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    kind,
  input  logic [CAN_ID_W-1:0]     can_id,
  input  logic [TIME_W-1:0]       time_us,
  input  logic [PERIOD_W-1:0]     period_ms,
  // Result words
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [VERD_W-1:0]       verdict,
  output logic [CAN_ID_W-1:0]     flagged_id,
  output logic signed [DEV_W-1:0] deviation_us
);

  logic [TOL_W-1:0] tolerance;
  logic             clearing;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  item_t            q_word;
  item_t            q_head;

  // Tolerance register; reset to the default window
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  // Front: accept and classify each word, flag out-of-range identifiers
  mpad_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .can_id     (can_id),
    .time_us    (time_us),
    .period_ms  (period_ms),
    .clearing   (clearing),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (q_word)
  );

  // Queue: decouple the input handshake from the table loop
  mpad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: read tables, compute deviation, write back, hold result until taken
  mpad_back #(
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tolerance    (tolerance),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .flagged_id   (flagged_id),
    .deviation_us (deviation_us)
  );

endmodule
